>>> sv/assert_macros.svh
// Assertion macros shared by the encoder servo PWM RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ESP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define ESP_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define ESP_ASSERT(lbl, clk, rstn, prop, msg)
`define ESP_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> sv/esp_pkg.sv
// Types and constants for the encoder stepped servo PWM block.
package esp_pkg;

  localparam int unsigned CFG_W   = 16;
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned DUTY_W  = 16;

  localparam logic [CFG_W-1:0] PERIOD_RST   = 16'd39999;
  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd3999;
  localparam logic [CFG_W-1:0] STEP_RST     = 16'd200;
  localparam logic [CFG_W-1:0] FLOOR_RST    = 16'd2000;
  localparam logic [CFG_W-1:0] CEILING_RST  = 16'd4000;
  localparam int unsigned      DUTY_RST_VAL = 1999;

  typedef enum logic [2:0] {
    REG_PERIOD   = 3'd0,
    REG_DEBOUNCE = 3'd1,
    REG_STEP     = 3'd2,
    REG_FLOOR    = 3'd3,
    REG_CEILING  = 3'd4
  } esp_reg_e;

  typedef struct packed {
    logic [CFG_W-1:0] pwm_period;
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] duty_step;
    logic [CFG_W-1:0] duty_floor;
    logic [CFG_W-1:0] duty_ceiling;
  } esp_cfg_t;

  typedef struct packed {
    logic              pwm_level;
    logic [DUTY_W-1:0] duty_now;
    logic              debouncing;
  } esp_res_t;

endpackage

>>> sv/esp_in_if.sv
// Input channel: one timer tick with the sampled encoder pins.
interface esp_in_if;
  logic valid;
  logic ready;
  logic pin_a;
  logic pin_b;

  modport source (output valid, output pin_a, output pin_b, input ready);
  modport sink (input valid, input pin_a, input pin_b, output ready);
endinterface

>>> sv/esp_out_if.sv
// Output channel: PWM level, duty and debounce status after one tick.
interface esp_out_if;
  logic        valid;
  logic        ready;
  logic        pwm_level;
  logic [15:0] duty_now;
  logic        debouncing;

  modport source (output valid, output pwm_level, output duty_now, output debouncing,
                  input ready);
  modport sink (input valid, input pwm_level, input duty_now, input debouncing,
                output ready);
endinterface

>>> sv/esp_regs.sv
// APB configuration registers for the encoder stepped servo PWM block.
module esp_regs
  import esp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output esp_cfg_t           cfg_o
);

  esp_cfg_t cfg_q;
  esp_cfg_t cfg_d;
  esp_reg_e idx;
  logic     wr_en;

  assign idx    = esp_reg_e'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_PERIOD:   cfg_d.pwm_period     = pwdata[CFG_W-1:0];
        REG_DEBOUNCE: cfg_d.debounce_ticks = pwdata[CFG_W-1:0];
        REG_STEP:     cfg_d.duty_step      = pwdata[CFG_W-1:0];
        REG_FLOOR:    cfg_d.duty_floor     = pwdata[CFG_W-1:0];
        REG_CEILING:  cfg_d.duty_ceiling   = pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PERIOD:   prdata = PDATA_W'(cfg_q.pwm_period);
      REG_DEBOUNCE: prdata = PDATA_W'(cfg_q.debounce_ticks);
      REG_STEP:     prdata = PDATA_W'(cfg_q.duty_step);
      REG_FLOOR:    prdata = PDATA_W'(cfg_q.duty_floor);
      REG_CEILING:  prdata = PDATA_W'(cfg_q.duty_ceiling);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pwm_period     <= PERIOD_RST;
      cfg_q.debounce_ticks <= DEBOUNCE_RST;
      cfg_q.duty_step      <= STEP_RST;
      cfg_q.duty_floor     <= FLOOR_RST;
      cfg_q.duty_ceiling   <= CEILING_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> sv/esp_tick.sv
// Per-tick state: debounce window, duty stepping and PWM counter.
`include "assert_macros.svh"
module esp_tick
  import esp_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  logic     pin_a_i,
  input  logic     pin_b_i,
  input  esp_cfg_t cfg_i,
  output esp_res_t res_o
);

  localparam int unsigned CW    = COUNT_WIDTH;
  localparam int unsigned CMP_W = (CW > CFG_W) ? CW : CFG_W;

  logic          prev_a_q, prev_a_d;
  logic          active_q, active_d;
  logic [CW-1:0] dcnt_q, dcnt_d;
  logic [CW-1:0] pcnt_q, pcnt_d;
  logic          pwm_q, pwm_d;
  logic [CW-1:0] duty_q, duty_d;

  logic [CMP_W-1:0] duty_ext;
  logic [CMP_W-1:0] step_ext;
  logic [CMP_W-1:0] diff;
  logic [CMP_W:0]   sum;
  logic [CW-1:0]    duty_adj;

  assign duty_ext = CMP_W'(duty_q);
  assign step_ext = CMP_W'(cfg_i.duty_step);
  assign diff     = duty_ext - step_ext;
  assign sum      = {1'b0, duty_ext} + {1'b0, step_ext};

  always_comb begin
    duty_adj = duty_q;
    if (!pin_b_i) begin
      if (duty_ext > CMP_W'(cfg_i.duty_floor)) begin
        duty_adj = (duty_ext > step_ext) ? CW'(diff) : '0;
      end
    end else if (duty_ext < CMP_W'(cfg_i.duty_ceiling)) begin
      duty_adj = (sum > (CMP_W+1)'({CW{1'b1}})) ? {CW{1'b1}} : CW'(sum);
    end
  end

  always_comb begin
    active_d = active_q;
    dcnt_d   = dcnt_q;
    duty_d   = duty_q;
    if (active_q) begin
      if (CMP_W'(dcnt_q) >= CMP_W'(cfg_i.debounce_ticks)) begin
        active_d = 1'b0;
        dcnt_d   = '0;
        if (!pin_a_i) begin
          duty_d = duty_adj;
        end
      end else if (dcnt_q == {CW{1'b1}}) begin
        dcnt_d = '0;
      end else begin
        dcnt_d = dcnt_q + 1'b1;
      end
    end else if (prev_a_q && !pin_a_i) begin
      active_d = 1'b1;
      dcnt_d   = '0;
    end
    prev_a_d = pin_a_i;

    if (CMP_W'(pcnt_q) >= CMP_W'(cfg_i.pwm_period) || pcnt_q == {CW{1'b1}}) begin
      pcnt_d = '0;
    end else begin
      pcnt_d = pcnt_q + 1'b1;
    end
    pwm_d = pwm_q;
    if (pcnt_d == duty_d) begin
      pwm_d = 1'b0;
    end
    if (CMP_W'(pcnt_d) == CMP_W'(cfg_i.pwm_period)) begin
      pwm_d = 1'b1;
    end
  end

  assign res_o.pwm_level  = pwm_d;
  assign res_o.duty_now   = DUTY_W'(duty_d);
  assign res_o.debouncing = active_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_a_q <= 1'b1;
      active_q <= 1'b0;
      dcnt_q   <= '0;
      pcnt_q   <= '0;
      pwm_q    <= 1'b0;
      duty_q   <= CW'(DUTY_RST_VAL);
    end else if (step_i) begin
      prev_a_q <= prev_a_d;
      active_q <= active_d;
      dcnt_q   <= dcnt_d;
      pcnt_q   <= pcnt_d;
      pwm_q    <= pwm_d;
      duty_q   <= duty_d;
    end
  end

  `ESP_NEVER(a_idle_cnt_zero, clk_i, rst_ni, !active_q && dcnt_q != '0, "count off window")
  `ESP_ASSERT(a_duty_on_step, clk_i, rst_ni, !step_i |=> $stable(duty_q), "duty moved idle")
  `ESP_ASSERT(a_window_start, clk_i, rst_ni, $rose(active_q) |-> $past(step_i && !pin_a_i),
              "window opened without falling A")

endmodule

>>> sv/encoder_stepped_servo_pwm.sv
// Top level of the encoder stepped servo PWM block.
//
//  channel  dir  payload                         handshake
//  in_if    in   pin_a, pin_b                    valid/ready
//  out_if   out  pwm_level, duty_now, debouncing valid/ready
//  apb      in   pwm_period .. duty_ceiling      psel/penable, pready=1
//
// One item per cycle while the output is not stalled; each result appears
// on out_if in the cycle after its item. The single output register sets
// the pace: in ready is high unless a result is held and out ready is low.
// Reset clears the output valid flag and loads the state and register resets.
`include "assert_macros.svh"
module encoder_stepped_servo_pwm
  import esp_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  esp_in_if.sink             in_if,
  esp_out_if.source          out_if,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  esp_cfg_t cfg;
  esp_res_t res;
  esp_res_t res_q;
  logic     out_valid_q;
  logic     in_ready;
  logic     in_fire;

  esp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  esp_tick #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_tick (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (in_fire),
    .pin_a_i (in_if.pin_a),
    .pin_b_i (in_if.pin_b),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  assign in_ready    = !out_valid_q || out_if.ready;
  assign in_fire     = in_if.valid && in_ready;
  assign in_if.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready) begin
      out_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.pwm_level  = res_q.pwm_level;
  assign out_if.duty_now   = res_q.duty_now;
  assign out_if.debouncing = res_q.debouncing;

  `ESP_ASSERT(a_fire_valid, clk_i, rst_ni, in_fire |=> out_valid_q, "item lost")
  `ESP_ASSERT(a_stall, clk_i, rst_ni, !in_ready |-> out_valid_q && !out_if.ready,
              "input stalled without cause")
  `ESP_ASSERT(a_drop, clk_i, rst_ni, $fell(out_valid_q) |-> $past(out_if.ready),
              "result dropped untaken")

endmodule
